// ===== rtl/core/vls_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vls_pkg
// Shared types and constants for the vector line sampler: coordinate and
// step widths, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package vls_pkg;

	// coordinate, step count and configuration widths
	localparam int COORD_WIDTH = 8;
	localparam int STEP_WIDTH  = 8;
	localparam int CFG_WIDTH   = 8;
	localparam int CFG_IDX_W   = 2;

	// divider: dividend is coordinate magnitude times step index
	localparam int DIVIDEND_W = COORD_WIDTH + STEP_WIDTH;
	localparam int DIV_CNT_W  = (COORD_WIDTH > 1) ? $clog2(COORD_WIDTH) : 1;

	localparam logic [STEP_WIDTH-1:0] STEP_MAX = {STEP_WIDTH{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_STEPS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_DIVISOR = 2'd2;

	// register reset values
	localparam logic [CFG_WIDTH-1:0] X_LIMIT_RST      = 8'd235;
	localparam logic [CFG_WIDTH-1:0] MIN_STEPS_RST    = 8'd3;
	localparam logic [CFG_WIDTH-1:0] STEP_DIVISOR_RST = 8'd3;

	// action codes of an input word
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_NEXT = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_DIV,
		ST_LOAD_END,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/vector_line_sampler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vector_line_sampler
// Line segment sampler for an XY vector display: one shared restoring
// divider, reused under a small sequencer, interpolates every point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes a word with action and the two
//   endpoints. A load word latches a segment and gives no output word. Each
//   next word gives one point (point_x, point_y, last_point) on the output
//   channel (out_valid/out_ready) while a segment is active; with no active
//   segment it is taken and dropped.
//   A load word is accepted, then runs 8 divider steps for the step count
//   and a clamp step. A next word is accepted, then per axis runs one
//   multiply step and 8 divider steps, then an output step to its point.
//   The single divider works at one quotient bit per cycle.
//   in_ready is high only while the sequencer is idle; one word is in work
//   at a time.
//   The output register holds a finished point while the receiver stalls;
//   the next word is taken meanwhile and its point waits in the sequencer
//   until the output register is free.
//   Reset clears the segment and restores x_limit 235, min_steps 3 and
//   step_divisor 3. Registers are written through cfg_we/cfg_index/cfg_data;
//   the user must write them only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module vector_line_sampler (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// configuration
	input  wire                                   cfg_we,
	input  wire  [vls_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire  [vls_pkg::CFG_WIDTH-1:0]         cfg_data,
	// input words
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire                                   action,
	input  wire  [vls_pkg::COORD_WIDTH-1:0]       x_start,
	input  wire  [vls_pkg::COORD_WIDTH-1:0]       y_start,
	input  wire  [vls_pkg::COORD_WIDTH-1:0]       x_end,
	input  wire  [vls_pkg::COORD_WIDTH-1:0]       y_end,
	// output words
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic [vls_pkg::COORD_WIDTH-1:0]       point_x,
	output logic [vls_pkg::COORD_WIDTH-1:0]       point_y,
	output logic                                  last_point
);

	localparam int CW = vls_pkg::COORD_WIDTH;
	localparam int SW = vls_pkg::STEP_WIDTH;
	localparam int DW = vls_pkg::DIVIDEND_W;
	localparam int NW = vls_pkg::DIV_CNT_W;

	// configuration registers
	logic [vls_pkg::CFG_WIDTH-1:0] x_limit_q;
	logic [vls_pkg::CFG_WIDTH-1:0] min_steps_q;
	logic [vls_pkg::CFG_WIDTH-1:0] step_divisor_q;

	// segment state
	logic [CW-1:0] start_x_q, start_y_q;
	logic [CW-1:0] mag_x_q, mag_y_q;
	logic          neg_x_q, neg_y_q;
	logic [SW-1:0] step_count_q, step_index_q;
	logic          active_q;

	// sequencer
	vls_pkg::state_t state_q, state_d;
	logic            axis_q;
	logic [CW-1:0]   quo_x_q;

	// shared divider
	logic [SW-1:0] div_rem_q;
	logic [CW-1:0] div_num_q;
	logic [SW-1:0] div_den_q;
	logic [CW-1:0] div_quo_q;
	logic [NW-1:0] div_cnt_q;
	logic          div_last;

	// output register
	logic          out_valid_q;
	logic [CW-1:0] point_x_q, point_y_q;
	logic          last_q;
	logic          out_free;

	logic          in_fire;

	assign in_ready   = (state_q == vls_pkg::ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign point_x    = point_x_q;
	assign point_y    = point_y_q;
	assign last_point = last_q;
	assign out_free   = !out_valid_q || out_ready;
	assign div_last   = (div_cnt_q == NW'(CW - 1));

	// load: axis magnitudes and larger distance
	logic [CW-1:0] adx, ady, big;
	logic [SW-1:0] div_sel, lo_sel;
	always_comb begin
		adx     = (x_end > x_start) ? (x_end - x_start) : (x_start - x_end);
		ady     = (y_end > y_start) ? (y_end - y_start) : (y_start - y_end);
		big     = (adx > ady) ? adx : ady;
		div_sel = (step_divisor_q == '0) ? SW'(1) : SW'(step_divisor_q);
		lo_sel  = (min_steps_q == '0) ? SW'(1) : SW'(min_steps_q);
	end

	// divider step: shift in one dividend bit, subtract if it fits
	logic [SW:0]   div_shift;
	logic          div_bit;
	logic [SW-1:0] div_rem_d;
	logic [CW-1:0] div_quo_d;
	always_comb begin
		div_shift = {div_rem_q, div_num_q[CW-1]};
		div_bit   = (div_shift >= {1'b0, div_den_q});
		div_rem_d = div_bit ? SW'(div_shift - {1'b0, div_den_q}) : div_shift[SW-1:0];
		div_quo_d = {div_quo_q[CW-2:0], div_bit};
	end

	// multiply: magnitude of the current axis times step index
	logic [CW-1:0] mul_mag;
	logic [DW-1:0] mul_prod;
	always_comb begin
		mul_mag  = axis_q ? mag_y_q : mag_x_q;
		mul_prod = DW'(mul_mag) * DW'(step_index_q);
	end

	// load end: clamp the step count
	logic [SW-1:0] steps_sat, steps_new;
	always_comb begin
		steps_sat = (div_quo_q > CW'(vls_pkg::STEP_MAX)) ? vls_pkg::STEP_MAX
		                                                 : SW'(div_quo_q);
		steps_new = (steps_sat < lo_sel) ? lo_sel : steps_sat;
	end

	// point: start plus or minus the quotient, x clamped to the limit
	logic [CW:0]   sum_x, sum_y;
	logic [CW-1:0] px_clamp;
	logic          is_last;
	always_comb begin
		sum_x    = neg_x_q ? ({1'b0, start_x_q} - {1'b0, quo_x_q})
		                   : ({1'b0, start_x_q} + {1'b0, quo_x_q});
		sum_y    = neg_y_q ? ({1'b0, start_y_q} - {1'b0, div_quo_q})
		                   : ({1'b0, start_y_q} + {1'b0, div_quo_q});
		px_clamp = (sum_x[CW-1:0] > CW'(x_limit_q)) ? CW'(x_limit_q) : sum_x[CW-1:0];
		is_last  = (step_index_q >= step_count_q);
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			vls_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (action == vls_pkg::ACT_LOAD)
						state_d = vls_pkg::ST_LOAD_DIV;
					else if (active_q)
						state_d = vls_pkg::ST_MUL;
				end
			end
			vls_pkg::ST_LOAD_DIV: begin
				if (div_last)
					state_d = vls_pkg::ST_LOAD_END;
			end
			vls_pkg::ST_LOAD_END: state_d = vls_pkg::ST_IDLE;
			vls_pkg::ST_MUL:      state_d = vls_pkg::ST_DIV;
			vls_pkg::ST_DIV: begin
				if (div_last)
					state_d = axis_q ? vls_pkg::ST_OUT : vls_pkg::ST_MUL;
			end
			vls_pkg::ST_OUT: begin
				if (out_free)
					state_d = vls_pkg::ST_IDLE;
			end
			default: state_d = vls_pkg::ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vls_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_limit_q      <= vls_pkg::X_LIMIT_RST;
			min_steps_q    <= vls_pkg::MIN_STEPS_RST;
			step_divisor_q <= vls_pkg::STEP_DIVISOR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				vls_pkg::REG_X_LIMIT:      x_limit_q      <= cfg_data;
				vls_pkg::REG_MIN_STEPS:    min_steps_q    <= cfg_data;
				vls_pkg::REG_STEP_DIVISOR: step_divisor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// segment control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			step_count_q <= '0;
			step_index_q <= '0;
		end else begin
			case (state_q)
				vls_pkg::ST_LOAD_END: begin
					step_count_q <= steps_new;
					step_index_q <= '0;
					active_q     <= 1'b1;
				end
				vls_pkg::ST_OUT: begin
					if (out_free) begin
						if (is_last)
							active_q <= 1'b0;
						else
							step_index_q <= step_index_q + SW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// segment payload and divider datapath
	always_ff @(posedge clk) begin
		case (state_q)
			vls_pkg::ST_IDLE: begin
				axis_q <= 1'b0;
				if (in_fire && action == vls_pkg::ACT_LOAD) begin
					start_x_q <= x_start;
					start_y_q <= y_start;
					mag_x_q   <= adx;
					mag_y_q   <= ady;
					neg_x_q   <= (x_start > x_end);
					neg_y_q   <= (y_start > y_end);
					div_rem_q <= '0;
					div_num_q <= big;
					div_den_q <= div_sel;
					div_quo_q <= '0;
					div_cnt_q <= '0;
				end
			end
			vls_pkg::ST_LOAD_DIV, vls_pkg::ST_DIV: begin
				div_rem_q <= div_rem_d;
				div_num_q <= {div_num_q[CW-2:0], 1'b0};
				div_quo_q <= div_quo_d;
				div_cnt_q <= div_cnt_q + NW'(1);
				if (state_q == vls_pkg::ST_DIV && div_last) begin
					if (!axis_q)
						quo_x_q <= div_quo_d;
					axis_q <= 1'b1;
				end
			end
			vls_pkg::ST_MUL: begin
				// high part of the product is already below the step count
				div_rem_q <= mul_prod[DW-1:CW];
				div_num_q <= mul_prod[CW-1:0];
				div_den_q <= step_count_q;
				div_quo_q <= '0;
				div_cnt_q <= '0;
			end
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == vls_pkg::ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == vls_pkg::ST_OUT && out_free) begin
			point_x_q <= px_clamp;
			point_y_q <= sum_y[CW-1:0];
			last_q    <= is_last;
		end
	end

`ifndef SYNTH
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (step_index_q <= step_count_q))
		else $error("step index beyond step count");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (step_count_q != '0))
		else $error("active segment with zero step count");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vls_pkg::ST_DIV || state_q == vls_pkg::ST_LOAD_DIV)
		|-> (div_rem_q < div_den_q))
		else $error("divider remainder not below divisor");

	a_out_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vls_pkg::ST_OUT && !out_free) |=> (state_q == vls_pkg::ST_OUT))
		else $error("point left sequencer while output register busy");
`endif

endmodule

`default_nettype wire
